### src/ersg_pkg.sv
`default_nettype none

package ersg_pkg;

    // input field widths, fixed point format
    localparam int RADIUS_W  = 13;
    localparam int FRAC_BITS = 8;
    localparam int INT_W     = RADIUS_W - FRAC_BITS;

    // output field widths
    localparam int ROW_W = INT_W + 1;
    localparam int PIX_W = 12;

    // shared multiplier operand and product widths
    localparam int SQ_W   = 2 * RADIUS_W;
    localparam int PROD_W = 2 * SQ_W;

    // j*j and x*x fit in twice the integer width
    localparam int ISQ_W = 2 * INT_W;

    // search bit counter
    localparam int BIT_W = $clog2(INT_W);

    // stream bus widths
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

endpackage

`default_nettype wire

### src/ellipse_row_span_generator_top.sv
// sequence: setup squares both radii once per request, then each row runs the search to its span
//   (skipped for a zero vertical radius or a row beyond it), plus output waits
// throughput: one request at a time, worked row by row, bounded by
//   the single shared 26x26 multiplier and the 5 step search per row
// reset: rst_n asynchronous active low, returns to idle with no span pending
`default_nettype none

module ellipse_row_span_generator_top
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // radius_i[12:0], radius_j[25:13], zero fill
    input  wire logic [ersg_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // row[5:0], first_col[11:6], last_col[17:12], centre_col[22:18],
    // centre_row[27:23], pixels_so_far[39:28]
    output logic [ersg_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RI2,
        S_RJ2,
        S_RJ2L,
        S_JSQ,
        S_DIFF,
        S_RHS,
        S_RHSL,
        S_SQ,
        S_SCALE,
        S_CMP,
        S_FIN,
        S_EMIT
    } state_t;

    state_t                              state_reg;
    logic [ersg_pkg::RADIUS_W-1:0]       radius_i_reg;
    logic [ersg_pkg::RADIUS_W-1:0]       radius_j_reg;
    logic [ersg_pkg::ROW_W-1:0]          row_reg;
    logic [ersg_pkg::PIX_W-1:0]          pixel_total_reg;
    logic [ersg_pkg::SQ_W-1:0]           ri2_reg;
    logic [ersg_pkg::SQ_W-1:0]           rj2_reg;
    logic [ersg_pkg::SQ_W-1:0]           diff_reg;
    logic [ersg_pkg::PROD_W-1:0]         rhs_reg;
    logic [ersg_pkg::PROD_W-1:0]         mul_reg;
    logic [ersg_pkg::INT_W-1:0]          x_reg;
    logic [ersg_pkg::BIT_W-1:0]          bit_reg;
    logic [ersg_pkg::ROW_W-1:0]          first_col_reg;
    logic [ersg_pkg::ROW_W-1:0]          last_col_reg;

    logic [ersg_pkg::INT_W-1:0]          hi;
    logic [ersg_pkg::INT_W-1:0]          hj;
    logic [ersg_pkg::ROW_W-1:0]          last_row;
    logic [ersg_pkg::INT_W-1:0]          j_off;
    logic [ersg_pkg::SQ_W-1:0]           sj2;
    logic [ersg_pkg::INT_W-1:0]          cand;
    logic [ersg_pkg::PROD_W-1:0]         lhs;
    logic                                cand_ok;
    logic [ersg_pkg::SQ_W-1:0]           op_a;
    logic [ersg_pkg::SQ_W-1:0]           op_b;
    logic                                s_fire;
    logic                                m_fire;
    logic                                is_last;

    // integer parts, the field width already caps them at the maximum
    assign hi       = radius_i_reg[ersg_pkg::RADIUS_W-1:ersg_pkg::FRAC_BITS];
    assign hj       = radius_j_reg[ersg_pkg::RADIUS_W-1:ersg_pkg::FRAC_BITS];
    assign last_row = {hj, 1'b0};
    assign is_last  = (row_reg == last_row);

    // vertical offset of the current row from the centre
    always_comb
    begin
        if (row_reg >= ersg_pkg::ROW_W'(hj))
            j_off = ersg_pkg::INT_W'(row_reg - ersg_pkg::ROW_W'(hj));
        else
            j_off = ersg_pkg::INT_W'(ersg_pkg::ROW_W'(hj) - row_reg);
    end

    // j*j scaled by 2^(2*frac), taken from the product register
    assign sj2 = {mul_reg[ersg_pkg::ISQ_W-1:0], {(2 * ersg_pkg::FRAC_BITS){1'b0}}};

    // search candidate and its test against the right hand side
    assign cand    = x_reg | (ersg_pkg::INT_W'(1) << bit_reg);
    assign lhs     = mul_reg << (2 * ersg_pkg::FRAC_BITS);
    assign cand_ok = (cand <= hi) && (lhs <= rhs_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            S_RI2:
            begin
                op_a = ersg_pkg::SQ_W'(radius_i_reg);
                op_b = ersg_pkg::SQ_W'(radius_i_reg);
            end
            S_RJ2:
            begin
                op_a = ersg_pkg::SQ_W'(radius_j_reg);
                op_b = ersg_pkg::SQ_W'(radius_j_reg);
            end
            S_JSQ:
            begin
                op_a = ersg_pkg::SQ_W'(j_off);
                op_b = ersg_pkg::SQ_W'(j_off);
            end
            S_RHS:
            begin
                op_a = ri2_reg;
                op_b = diff_reg;
            end
            S_SQ:
            begin
                op_a = ersg_pkg::SQ_W'(cand);
                op_b = ersg_pkg::SQ_W'(cand);
            end
            S_SCALE:
            begin
                op_a = ersg_pkg::SQ_W'(mul_reg[ersg_pkg::ISQ_W-1:0]);
                op_b = rj2_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_EMIT);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    assign m_tdata = {pixel_total_reg, hj, hi, last_col_reg, first_col_reg, row_reg};
    assign m_tlast = is_last;

    // sequencer with the shared multiplier and all registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            radius_i_reg    <= '0;
            radius_j_reg    <= '0;
            row_reg         <= '0;
            pixel_total_reg <= '0;
            ri2_reg         <= '0;
            rj2_reg         <= '0;
            diff_reg        <= '0;
            rhs_reg         <= '0;
            mul_reg         <= '0;
            x_reg           <= '0;
            bit_reg         <= '0;
            first_col_reg   <= '0;
            last_col_reg    <= '0;
        end
        else
        begin
            mul_reg <= ersg_pkg::PROD_W'(op_a) * ersg_pkg::PROD_W'(op_b);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        radius_i_reg    <= s_tdata[ersg_pkg::RADIUS_W-1:0];
                        radius_j_reg    <= s_tdata[2*ersg_pkg::RADIUS_W-1:ersg_pkg::RADIUS_W];
                        row_reg         <= '0;
                        pixel_total_reg <= '0;
                        state_reg       <= S_RI2;
                    end
                end
                S_RI2:
                begin
                    state_reg <= S_RJ2;
                end
                S_RJ2:
                begin
                    ri2_reg   <= mul_reg[ersg_pkg::SQ_W-1:0];
                    state_reg <= S_RJ2L;
                end
                S_RJ2L:
                begin
                    rj2_reg   <= mul_reg[ersg_pkg::SQ_W-1:0];
                    state_reg <= S_JSQ;
                end
                S_JSQ:
                begin
                    state_reg <= S_DIFF;
                end
                // degenerate rows skip the search
                S_DIFF:
                begin
                    if (radius_j_reg == '0)
                    begin
                        x_reg     <= hi;
                        state_reg <= S_FIN;
                    end
                    else if (sj2 > rj2_reg)
                    begin
                        x_reg     <= '0;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        diff_reg  <= rj2_reg - sj2;
                        state_reg <= S_RHS;
                    end
                end
                S_RHS:
                begin
                    state_reg <= S_RHSL;
                end
                S_RHSL:
                begin
                    rhs_reg   <= mul_reg;
                    x_reg     <= '0;
                    bit_reg   <= ersg_pkg::BIT_W'(ersg_pkg::INT_W - 1);
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    state_reg <= S_SCALE;
                end
                S_SCALE:
                begin
                    state_reg <= S_CMP;
                end
                // keep the candidate bit if the span still fits
                S_CMP:
                begin
                    if (cand_ok)
                        x_reg <= cand;
                    if (bit_reg == '0)
                        state_reg <= S_FIN;
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= S_SQ;
                    end
                end
                S_FIN:
                begin
                    first_col_reg   <= ersg_pkg::ROW_W'(hi) - ersg_pkg::ROW_W'(x_reg);
                    last_col_reg    <= ersg_pkg::ROW_W'(hi) + ersg_pkg::ROW_W'(x_reg);
                    pixel_total_reg <= pixel_total_reg + ersg_pkg::PIX_W'({x_reg, 1'b1});
                    state_reg       <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (m_fire)
                    begin
                        if (is_last)
                            state_reg <= S_IDLE;
                        else
                        begin
                            row_reg   <= row_reg + 1'b1;
                            state_reg <= S_JSQ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // never take a request while a span is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
    else $error("input ready while a span is pending");

    // a request always starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_tready)
    else $error("accepted request did not start the sequencer");

    // a span that is not the last is followed by more work
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_fire && !m_tlast) |=> (!s_tready && row_reg == $past(row_reg) + 1'b1))
    else $error("spans ended before the bottom row");

    // the span straddles the centre column
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (first_col_reg <= ersg_pkg::ROW_W'(hi)
                      && last_col_reg >= ersg_pkg::ROW_W'(hi)))
    else $error("span does not cover the centre column");

    // the row index stays inside the box
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (row_reg <= last_row))
    else $error("row index beyond the bottom row");

endmodule

`default_nettype wire
